>>> rtl/lps_pkg.sv
`default_nettype none

package lps_pkg;

  // Shared shift-add multiplier: operand A is taken in parallel, operand B one bit a cycle.
  localparam int unsigned MUL_AW = 32;
  localparam int unsigned MUL_BW = 16;
  localparam int unsigned MUL_PW = MUL_AW + MUL_BW;
  localparam int unsigned MUL_CW = $clog2(MUL_BW + 1);

  typedef struct packed {
    logic              start;
    logic [MUL_AW-1:0] a;
    logic [MUL_BW-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [MUL_PW-1:0] prod;
  } mul_rsp_t;

  // Fixed-point constants, Q0.16 unless noted.
  localparam logic [31:0] LUM_FLOOR   = 32'd7;
  localparam logic [14:0] DT_MAX      = 15'd16384;
  localparam logic [16:0] ONE_Q16     = 17'd65536;
  localparam logic [16:0] BIAS_HALF   = 17'd32768;
  localparam logic [15:0] BIAS_SCALE  = 16'd14418;
  localparam logic [13:0] DARK_R      = 14'd9503;
  localparam logic [15:0] SPAN_R      = 16'd4129;
  localparam logic [14:0] R_MIN       = 15'd4588;
  localparam logic [14:0] R_MAX       = 15'd10158;
  localparam logic [29:0] ROUND_Q16   = 30'd32768;
  localparam logic [29:0] ROUND_Q14   = 30'd8192;
  localparam logic [63:0] EXP_ARG_Q32 = 64'd3435973837;

endpackage

`default_nettype wire

>>> rtl/lps_sermul.sv
`default_nettype none

module lps_sermul (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lps_pkg::mul_req_t req_i,
  output lps_pkg::mul_rsp_t      rsp_o
);

  logic [lps_pkg::MUL_AW-1:0] a_q, a_d;
  logic [lps_pkg::MUL_AW-1:0] hi_q, hi_d;
  logic [lps_pkg::MUL_BW-1:0] lo_q, lo_d;
  logic [lps_pkg::MUL_CW-1:0] cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [lps_pkg::MUL_AW:0]   sum;

  always_comb begin
    sum    = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);
    a_d    = a_q;
    hi_d   = hi_q;
    lo_d   = lo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      a_d    = req_i.a;
      hi_d   = '0;
      lo_d   = req_i.b;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // add on the low multiplier bit, then shift the whole product right
      hi_d  = sum[lps_pkg::MUL_AW:1];
      lo_d  = {sum[0], lo_q[lps_pkg::MUL_BW-1:1]};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == lps_pkg::MUL_CW'(lps_pkg::MUL_BW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q  <= a_d;
    hi_q <= hi_d;
    lo_q <= lo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = {hi_q, lo_q};

endmodule

`default_nettype wire

>>> rtl/log_luminance_pupil_smoother_unit.sv
// Each input word runs a normalizing shift of k steps, where
//   k = 32 - (leading-one position of max(L,7) + 65536), then five passes of the shared
//   bit-serial multiplier, a bit-serial divide by three and two table reads. A new input
//   word is taken only in S_IDLE, once the last result has gone into the output register.
// Reset (rst_ni low, asynchronous): radius 0.145 (9503), bias 0.5 (32768), no result pending.
`default_nettype none

module log_luminance_pupil_smoother_unit #(
  parameter int unsigned LOG_FRAC_ENTRIES = 256,
  parameter int unsigned ALPHA_ENTRIES    = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] scene_luminance_i,
  input  wire logic [15:0] delta_time_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [13:0]      target_radius_o,
  output logic [13:0]      smoothed_radius_o,
  input  wire logic        cfg_we_i,
  input  wire logic [16:0] cfg_wdata_i
);

  localparam int unsigned LOG_IDX_W   = $clog2(LOG_FRAC_ENTRIES);
  localparam int unsigned ALPHA_IDX_W = $clog2(ALPHA_ENTRIES);
  localparam int unsigned ALPHA_DEN   = ALPHA_ENTRIES - 1;
  localparam logic [lps_pkg::MUL_BW-1:0] LOG_SCALE_B   = lps_pkg::MUL_BW'(LOG_FRAC_ENTRIES);
  localparam logic [lps_pkg::MUL_BW-1:0] ALPHA_SCALE_B = lps_pkg::MUL_BW'(ALPHA_DEN);
  localparam logic [ALPHA_IDX_W-1:0]     ALPHA_IDX_MAX = ALPHA_IDX_W'(ALPHA_DEN);
  localparam logic [4:0]                 DIV_LAST      = 5'd20;

  // ---------------------------------------------------------------------------------------
  // Constant tables, built at elaboration.
  //   log table:   entry i = log2(1 + i/N) in Q0.16, by bit-wise squaring of the mantissa.
  //   alpha table: entry k = 1 - exp(-0.8 k/(M-1)) in Q0.16, by a 24-term series.
  // ---------------------------------------------------------------------------------------
  typedef logic [16:0] log_rom_t   [LOG_FRAC_ENTRIES];
  typedef logic [15:0] alpha_rom_t [ALPHA_ENTRIES];

  function automatic logic [16:0] log2_frac(input logic [63:0] num);
    logic [63:0] m;
    logic [16:0] bits;
    logic [17:0] rnd;
    m    = (num << 30) / LOG_FRAC_ENTRIES;
    bits = '0;
    for (int n = 0; n < 17; n++) begin
      m    = (m * m) >> 30;
      bits = {bits[15:0], 1'b0};
      if (m >= (64'd2 << 30)) begin
        bits[0] = 1'b1;
        m       = m >> 1;
      end
    end
    rnd = ({1'b0, bits} + 18'd1) >> 1;
    return rnd[16:0];
  endfunction

  function automatic logic [15:0] one_minus_exp(input logic [63:0] y);
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] e;
    logic [63:0] r;
    term = 64'd1 << 32;
    pos  = term;
    neg  = '0;
    for (int unsigned n = 1; n < 24; n++) begin
      term = ((term * y) >> 32) / 64'(n);
      if (n[0]) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    e = pos - neg;
    if (e > (64'd1 << 32)) begin
      e = 64'd1 << 32;
    end
    r = ((64'd1 << 32) - e + 64'd32768) >> 16;
    return r[15:0];
  endfunction

  function automatic log_rom_t build_log_rom();
    log_rom_t rom;
    for (int unsigned i = 0; i < LOG_FRAC_ENTRIES; i++) begin
      rom[i] = log2_frac(64'(LOG_FRAC_ENTRIES + i));
    end
    return rom;
  endfunction

  function automatic alpha_rom_t build_alpha_rom();
    alpha_rom_t rom;
    for (int unsigned i = 0; i < ALPHA_ENTRIES; i++) begin
      rom[i] = one_minus_exp((64'(i) * lps_pkg::EXP_ARG_Q32) / ALPHA_DEN);
    end
    return rom;
  endfunction

  localparam log_rom_t   LOG_ROM   = build_log_rom();
  localparam alpha_rom_t ALPHA_ROM = build_alpha_rom();

  // ---------------------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------------------
  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,  // wait for an input word
    S_NORM   = 9'b000000010,  // shift left until the leading one reaches bit 32
    S_LAUNCH = 9'b000000100,  // start the multiplier on the operands of op_q
    S_MUL    = 9'b000001000,  // wait for the product, then consume it
    S_LOGRD  = 9'b000010000,  // log table read
    S_DIVLD  = 9'b000100000,  // assemble log2 value
    S_DIV    = 9'b001000000,  // divide by three, one quotient bit a cycle
    S_ARD    = 9'b010000000,  // alpha table read
    S_DONE   = 9'b100000000   // update radius, hand the word to the output register
  } state_e;

  typedef enum logic [2:0] {
    OP_IDX,   // fraction * N -> log table index
    OP_MAG,   // |0.5 - bias| * 0.22
    OP_TGT,   // biased response * (dark - bright)
    OP_AIDX,  // dt * (M-1) -> alpha table index
    OP_STEP   // |target - radius| * alpha
  } op_e;

  state_e                 state_q, state_d;
  op_e                    op_q, op_d;
  logic [32:0]            x_q, x_d;
  logic [4:0]             k_q, k_d;
  logic [14:0]            dt_q, dt_d;
  logic [LOG_IDX_W-1:0]   log_idx_q, log_idx_d;
  logic [ALPHA_IDX_W-1:0] aidx_q, aidx_d;
  logic [16:0]            log_frac_q;
  logic [15:0]            alpha_q;
  logic [20:0]            dvd_q, dvd_d;
  logic [1:0]             rem_q, rem_d;
  logic [4:0]             cnt_q, cnt_d;
  logic [16:0]            biased_q, biased_d;
  logic [13:0]            target_q, target_d;
  logic                   dir_q, dir_d;
  logic [13:0]            step_q, step_d;
  logic [13:0]            cur_q, cur_d;
  logic [16:0]            bias_q, bias_d;
  logic                   out_valid_q, out_valid_d;
  logic [13:0]            out_target_q, out_target_d;
  logic [13:0]            out_radius_q, out_radius_d;

  lps_pkg::mul_req_t mul_req;
  lps_pkg::mul_rsp_t mul_rsp;

  logic [31:0] lum_fl;
  logic [16:0] bias_c;
  logic        bias_lo;
  logic [16:0] mag_full;
  logic [16:0] resp;
  logic [29:0] rnd16;
  logic [29:0] rnd14;
  logic [15:0] aidx_full;
  logic [13:0] prod_q16;
  logic [17:0] add_sum;
  logic [13:0] diff;
  logic [2:0]  div_t;
  logic        div_ge;
  logic [4:0]  pint;
  logic [14:0] rad_sum;
  logic [13:0] rad_new;

  lps_sermul u_sermul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  // Datapath pieces shared by several states.
  always_comb begin
    lum_fl   = (scene_luminance_i < lps_pkg::LUM_FLOOR) ? lps_pkg::LUM_FLOOR
                                                        : scene_luminance_i;
    // clamp bias to 1.0, then split into direction and magnitude around 0.5
    bias_c   = (bias_q > lps_pkg::ONE_Q16) ? lps_pkg::ONE_Q16 : bias_q;
    bias_lo  = (bias_c <= lps_pkg::BIAS_HALF);
    mag_full = bias_lo ? (lps_pkg::BIAS_HALF - bias_c) : (bias_c - lps_pkg::BIAS_HALF);
    // quotient of the divide, clamped to 1.0
    resp     = (dvd_q > 21'(lps_pkg::ONE_Q16)) ? lps_pkg::ONE_Q16 : dvd_q[16:0];
    // every product consumed with rounding stays below 2^29
    rnd16    = {1'b0, mul_rsp.prod[28:0]} + lps_pkg::ROUND_Q16;
    rnd14    = {1'b0, mul_rsp.prod[28:0]} + lps_pkg::ROUND_Q14;
    prod_q16 = rnd16[29:16];
    aidx_full = rnd14[29:14];
    add_sum  = {1'b0, resp} + {4'b0, prod_q16};
    diff     = (target_q >= cur_q) ? (target_q - cur_q) : (cur_q - target_q);
    // restoring divide by three, one bit a cycle
    div_t    = {rem_q, dvd_q[20]};
    div_ge   = (div_t >= 3'd3);
    pint     = 5'd16 - k_q;
    rad_sum  = dir_q ? ({1'b0, cur_q} + {1'b0, step_q}) : ({1'b0, cur_q} - {1'b0, step_q});
    if (rad_sum < lps_pkg::R_MIN) begin
      rad_new = lps_pkg::R_MIN[13:0];
    end else if (rad_sum > lps_pkg::R_MAX) begin
      rad_new = lps_pkg::R_MAX[13:0];
    end else begin
      rad_new = rad_sum[13:0];
    end
  end

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    x_d          = x_q;
    k_d          = k_q;
    dt_d         = dt_q;
    log_idx_d    = log_idx_q;
    aidx_d       = aidx_q;
    dvd_d        = dvd_q;
    rem_d        = rem_q;
    cnt_d        = cnt_q;
    biased_d     = biased_q;
    target_d     = target_q;
    dir_d        = dir_q;
    step_d       = step_q;
    cur_d        = cur_q;
    out_target_d = out_target_q;
    out_radius_d = out_radius_q;
    // drop the pending result once the consumer takes it
    out_valid_d  = out_valid_q && !out_ready_i;
    bias_d       = cfg_we_i ? cfg_wdata_i : bias_q;
    in_ready_o   = 1'b0;
    mul_req      = '0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          x_d     = {1'b0, lum_fl} + 33'h1_0000;
          k_d     = '0;
          dt_d    = (delta_time_i > {1'b0, lps_pkg::DT_MAX}) ? lps_pkg::DT_MAX
                                                             : delta_time_i[14:0];
          state_d = S_NORM;
        end
      end

      S_NORM: begin
        if (x_q[32]) begin
          op_d    = OP_IDX;
          state_d = S_LAUNCH;
        end else begin
          x_d = {x_q[31:0], 1'b0};
          k_d = k_q + 5'd1;
        end
      end

      S_LAUNCH: begin
        mul_req.start = 1'b1;
        unique case (op_q)
          OP_IDX: begin
            // normalized fraction sits in bits 31:0; index = (frac * N) >> 32
            mul_req.a = x_q[31:0];
            mul_req.b = LOG_SCALE_B;
          end
          OP_MAG: begin
            mul_req.a = lps_pkg::MUL_AW'(mag_full);
            mul_req.b = lps_pkg::BIAS_SCALE;
          end
          OP_TGT: begin
            mul_req.a = lps_pkg::MUL_AW'(biased_q);
            mul_req.b = lps_pkg::SPAN_R;
          end
          OP_AIDX: begin
            mul_req.a = lps_pkg::MUL_AW'(dt_q);
            mul_req.b = ALPHA_SCALE_B;
          end
          OP_STEP: begin
            mul_req.a = lps_pkg::MUL_AW'(diff);
            mul_req.b = alpha_q;
            dir_d     = (target_q >= cur_q);
          end
          default: begin
            mul_req.start = 1'b0;
          end
        endcase
        state_d = S_MUL;
      end

      S_MUL: begin
        if (mul_rsp.done) begin
          unique case (op_q)
            OP_IDX: begin
              log_idx_d = mul_rsp.prod[lps_pkg::MUL_AW +: LOG_IDX_W];
              state_d   = S_LOGRD;
            end
            OP_MAG: begin
              // shift the response by the rounded bias term, clamp to [0, 1.0]
              if (bias_lo) begin
                biased_d = (add_sum > {1'b0, lps_pkg::ONE_Q16}) ? lps_pkg::ONE_Q16
                                                                 : add_sum[16:0];
              end else begin
                biased_d = ({3'b0, prod_q16} > resp) ? '0 : (resp - {3'b0, prod_q16});
              end
              op_d    = OP_TGT;
              state_d = S_LAUNCH;
            end
            OP_TGT: begin
              target_d = lps_pkg::DARK_R - prod_q16;
              op_d     = OP_AIDX;
              state_d  = S_LAUNCH;
            end
            OP_AIDX: begin
              aidx_d  = (aidx_full > 16'(ALPHA_DEN)) ? ALPHA_IDX_MAX
                                                     : aidx_full[ALPHA_IDX_W-1:0];
              state_d = S_ARD;
            end
            OP_STEP: begin
              step_d  = prod_q16;
              state_d = S_DONE;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_LOGRD: begin
        state_d = S_DIVLD;
      end

      S_DIVLD: begin
        // log2 value in Q5.16: integer part from the shift count, fraction from the table
        dvd_d   = {pint, 16'h0000} + {4'b0, log_frac_q};
        rem_d   = '0;
        cnt_d   = '0;
        state_d = S_DIV;
      end

      S_DIV: begin
        rem_d = div_ge ? 2'(div_t - 3'd3) : div_t[1:0];
        dvd_d = {dvd_q[19:0], div_ge};
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == DIV_LAST) begin
          op_d    = OP_MAG;
          state_d = S_LAUNCH;
        end
      end

      S_ARD: begin
        op_d    = OP_STEP;
        state_d = S_LAUNCH;
      end

      S_DONE: begin
        // hold the new radius until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cur_d        = rad_new;
          out_target_d = target_q;
          out_radius_d = rad_new;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_IDX;
      cnt_q       <= '0;
      cur_q       <= lps_pkg::DARK_R;
      bias_q      <= lps_pkg::BIAS_HALF;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      cnt_q       <= cnt_d;
      cur_q       <= cur_d;
      bias_q      <= bias_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q          <= x_d;
    k_q          <= k_d;
    dt_q         <= dt_d;
    log_idx_q    <= log_idx_d;
    aidx_q       <= aidx_d;
    dvd_q        <= dvd_d;
    rem_q        <= rem_d;
    biased_q     <= biased_d;
    target_q     <= target_d;
    dir_q        <= dir_d;
    step_q       <= step_d;
    out_target_q <= out_target_d;
    out_radius_q <= out_radius_d;
  end

  // Table reads, registered; the address is settled in the state before S_LOGRD or S_ARD.
  always_ff @(posedge clk_i) begin
    log_frac_q <= LOG_ROM[log_idx_q];
    alpha_q    <= ALPHA_ROM[aidx_q];
  end

  assign out_valid_o       = out_valid_q;
  assign target_radius_o   = out_target_q;
  assign smoothed_radius_o = out_radius_q;

endmodule

`default_nettype wire
